@@ src/stream_reassembly_gap_tracker_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the stream reassembly gap tracker.
// Each macro expands to one labeled concurrent assertion.
// ---------------------------------------------------------------------------
`ifndef STREAM_REASSEMBLY_GAP_TRACKER_UNIT_DEFINES_SVH
`define STREAM_REASSEMBLY_GAP_TRACKER_UNIT_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define SRGT_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SRGT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/srgt_pkg.sv @@
// ---------------------------------------------------------------------------
// srgt_pkg
// Shared types and constants of the stream reassembly gap tracker.
// ---------------------------------------------------------------------------
`default_nettype none

package srgt_pkg;

    localparam int OFS_W       = 62;
    localparam int POS_W       = 63;
    localparam int LEN_W       = 16;
    localparam int LIM_W       = 7;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 144;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * OFS_W - LEN_W;

    localparam logic [OFS_W-1:0] OFS_MAX     = '1;
    localparam logic [LIM_W-1:0] LIMIT_RESET = 7'd64;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_IGNORED  = 2'd1,
        STAT_TOO_MANY = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

    // One gap: the unfilled range [start, end).
    typedef struct packed {
        logic [OFS_W-1:0] start;
        logic [OFS_W-1:0] stop;
    } gap_t;

    // Command to one gap cell.
    typedef enum logic [2:0] {
        GAP_HOLD       = 3'd0,
        GAP_LOAD_START = 3'd1,
        GAP_LOAD_END   = 3'd2,
        GAP_LOAD_BOTH  = 3'd3,
        GAP_TAKE_LEFT  = 3'd4,
        GAP_TAKE_RIGHT = 3'd5
    } gap_cmd_t;

    // One queued frame.
    typedef struct packed {
        logic [OFS_W-1:0] offset;
        logic [LEN_W-1:0] length;
        logic             fin;
    } frame_t;

    // Control to one frame cell.
    typedef struct packed {
        logic wr;
        logic clr;
    } frame_ctl_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_POP,
        S_SAME,
        S_GFIND,
        S_JFIND,
        S_PLAN,
        S_DROP,
        S_MOD,
        S_SHIFT,
        S_CHECK,
        S_STORE,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

@@ src/srgt_gap_cell.sv @@
// ---------------------------------------------------------------------------
// srgt_gap_cell
// One entry of the sorted gap list; shifts to or from its neighbors.
// ---------------------------------------------------------------------------
`default_nettype none

module srgt_gap_cell #(
    parameter bit HEAD = 1'b0
) (
    input  wire                clk,
    input  wire                rst_n,
    input  srgt_pkg::gap_cmd_t cmd,
    input  srgt_pkg::gap_t     load_val,
    input  srgt_pkg::gap_t     left,
    input  srgt_pkg::gap_t     right,
    output srgt_pkg::gap_t     q
);

    srgt_pkg::gap_t gap_reg;
    srgt_pkg::gap_t gap_next;

    // Next value of the entry.
    always_comb
    begin
        gap_next = gap_reg;
        unique case (cmd)
            srgt_pkg::GAP_HOLD:       gap_next = gap_reg;
            srgt_pkg::GAP_LOAD_START: gap_next.start = load_val.start;
            srgt_pkg::GAP_LOAD_END:   gap_next.stop = load_val.stop;
            srgt_pkg::GAP_LOAD_BOTH:  gap_next = load_val;
            srgt_pkg::GAP_TAKE_LEFT:  gap_next = left;
            srgt_pkg::GAP_TAKE_RIGHT: gap_next = right;
            default:                  gap_next = gap_reg;
        endcase
    end

    // The head cell starts as the gap over the whole offset space.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg.start <= '0;
            gap_reg.stop  <= HEAD ? srgt_pkg::OFS_MAX : '0;
        end
        else
        begin
            gap_reg <= gap_next;
        end
    end

    assign q = gap_reg;

endmodule

`default_nettype wire

@@ src/srgt_frame_cell.sv @@
// ---------------------------------------------------------------------------
// srgt_frame_cell
// One slot of the queued frame table with its own offset compare.
// ---------------------------------------------------------------------------
`default_nettype none

module srgt_frame_cell (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire [srgt_pkg::OFS_W-1:0]     key,
    input  srgt_pkg::frame_ctl_t          ctl,
    input  srgt_pkg::frame_t              wr_data,
    output srgt_pkg::frame_t              entry,
    output logic                          valid,
    output logic                          match
);

    srgt_pkg::frame_t entry_reg;
    logic             valid_reg;
    logic             valid_next;

    // A write sets the slot, a clear frees it.
    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.wr)
        begin
            valid_next = 1'b1;
        end
        else if (ctl.clr)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Frame payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            entry_reg <= wr_data;
        end
    end

    assign entry = entry_reg;
    assign valid = valid_reg;
    assign match = valid_reg && (entry_reg.offset == key);

endmodule

`default_nettype wire

@@ src/stream_reassembly_gap_tracker_unit.sv @@
// ---------------------------------------------------------------------------
// stream_reassembly_gap_tracker_unit
// Gap list and frame table for reassembling out-of-order stream frames.
// ---------------------------------------------------------------------------
// Requests enter on the s_ stream: s_tuser is the operation (push or pop),
// s_tdata carries the frame offset and length, s_tlast the end-of-stream mark.
// Every request gives exactly one result on the m_ stream: m_tuser holds the
// status, m_tdata the reported frame and the read position, m_tlast the mark.
// A pop passes the pop lookup, then the result state. A push that reaches the
// gap update passes the same-offset check, both gap searches, the plan, the
// frame drops (one per gap end passed, on the shared compare), the bound edits,
// the gap shift (one cell shift per gap removed), the limit check and the
// store; a push ignored early skips to the result state. One request is worked
// on at a time: s_tready is high only in idle. A request may be accepted while
// the last result waits on m_tready; its own result then waits in the sequencer
// until the output register is free, so a stalled receiver stalls. Reset
// empties the frame table, sets one gap over all offsets, the read position to
// zero and the gap limit to 64. The gap limit is written through cfg_wr_en and
// cfg_wr_data, by the user only while idle; the block does not enforce it.
// ---------------------------------------------------------------------------
`default_nettype none

`include "stream_reassembly_gap_tracker_unit_defines.svh"

module stream_reassembly_gap_tracker_unit #(
    parameter int MAX_GAPS   = 64,
    parameter int MAX_FRAMES = 64
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // tdata: frame_offset[61:0], frame_length[77:62], zero[79:78]
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire [srgt_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  wire                                  s_tuser,   // op
    input  wire                                  s_tlast,   // frame_fin
    // tdata: out_offset[61:0], out_length[77:62], read_offset[139:78], zero
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [srgt_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic [1:0]                           m_tuser,   // status
    output logic                                 m_tlast,   // out_fin
    input  wire                                  cfg_wr_en,
    input  wire [srgt_pkg::LIM_W-1:0]            cfg_wr_data
);

    localparam int GI_W  = $clog2(MAX_GAPS);
    localparam int GC_W  = $clog2(MAX_GAPS + 1);
    localparam int FI_W  = $clog2(MAX_FRAMES);
    localparam int CMP_W = (GC_W > srgt_pkg::LIM_W) ? GC_W : srgt_pkg::LIM_W;
    localparam int OFS_W = srgt_pkg::OFS_W;
    localparam int POS_W = srgt_pkg::POS_W;
    localparam int LEN_W = srgt_pkg::LEN_W;

    // Control registers.
    srgt_pkg::state_t              state_reg, state_next;
    logic [GC_W-1:0]               count_reg, count_next;
    logic [OFS_W-1:0]              rpos_reg, rpos_next;
    logic [srgt_pkg::LIM_W-1:0]    limit_reg, limit_next;
    logic                          m_valid_reg, m_valid_next;

    // Working registers of the current request.
    logic                          op_reg, op_next;
    logic [OFS_W-1:0]              off_reg, off_next;
    logic [LEN_W-1:0]              len_reg, len_next;
    logic                          fin_reg, fin_next;
    logic [POS_W-1:0]              start_reg, start_next;
    logic [POS_W-1:0]              end_reg, end_next;
    logic [GI_W-1:0]               g_reg, g_next;
    logic [GI_W-1:0]               j_reg, j_next;
    logic [GI_W-1:0]               k_reg, k_next;
    logic [OFS_W-1:0]              gs_g_reg, gs_g_next;
    logic [OFS_W-1:0]              ge_g_reg, ge_g_next;
    logic [OFS_W-1:0]              ge_j_reg, ge_j_next;
    logic                          keep_j_reg, keep_j_next;
    logic                          split_reg, split_next;
    logic                          mod_gs_g_reg, mod_gs_g_next;
    logic                          mod_ge_g_reg, mod_ge_g_next;
    logic                          mod_gs_j_reg, mod_gs_j_next;
    logic [GC_W-1:0]               ndel_reg, ndel_next;
    logic [GC_W-1:0]               pdel_reg, pdel_next;
    srgt_pkg::status_t             status_reg, status_next;

    // Output register payload.
    logic [srgt_pkg::OUT_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [1:0]                       m_user_reg, m_user_next;
    logic                             m_last_reg, m_last_next;

    // Gap cells.
    srgt_pkg::gap_t      gap_q   [MAX_GAPS];
    srgt_pkg::gap_cmd_t  gap_cmd [MAX_GAPS];
    srgt_pkg::gap_t      gap_load;

    // Frame cells.
    srgt_pkg::frame_t     frm_q   [MAX_FRAMES];
    srgt_pkg::frame_ctl_t frm_ctl [MAX_FRAMES];
    srgt_pkg::frame_t     frm_wdata;
    logic [MAX_FRAMES-1:0] frm_valid;
    logic [MAX_FRAMES-1:0] frm_match;
    logic [OFS_W-1:0]      frm_key;

    // Scan results.
    logic [MAX_GAPS-1:0]   c_hit, e_flag, lt_flag, le_next, d_hit;
    logic                  g_found;
    logic [GI_W-1:0]       g_idx;
    logic [GI_W-1:0]       j_idx;
    logic                  hit;
    logic [LEN_W-1:0]      hit_len;
    logic                  hit_fin;
    logic                  free_found;
    logic [FI_W-1:0]       free_idx;
    logic [GC_W-1:0]       count_last;
    logic [POS_W-1:0]      span;

    // Row of gap cells, each wired to its neighbors.
    for (genvar gi = 0; gi < MAX_GAPS; gi++)
    begin : g_gap
        srgt_pkg::gap_t left_v;
        srgt_pkg::gap_t right_v;
        if (gi == 0)
        begin : g_l0
            assign left_v = gap_q[gi];
        end
        else
        begin : g_ln
            assign left_v = gap_q[gi-1];
        end
        if (gi == MAX_GAPS - 1)
        begin : g_rl
            assign right_v = gap_q[gi];
        end
        else
        begin : g_rn
            assign right_v = gap_q[gi+1];
        end
        srgt_gap_cell #(
            .HEAD (gi == 0)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (gap_cmd[gi]),
            .load_val (gap_load),
            .left     (left_v),
            .right    (right_v),
            .q        (gap_q[gi])
        );
    end

    // Row of frame cells.
    for (genvar fi = 0; fi < MAX_FRAMES; fi++)
    begin : g_frm
        srgt_frame_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .key     (frm_key),
            .ctl     (frm_ctl[fi]),
            .wr_data (frm_wdata),
            .entry   (frm_q[fi]),
            .valid   (frm_valid[fi]),
            .match   (frm_match[fi])
        );
    end

    assign count_last = count_reg - GC_W'(1);
    assign span       = end_reg - start_reg;

    // Per-cell gap compares.
    always_comb
    begin
        for (int i = 0; i < MAX_GAPS; i++)
        begin
            e_flag[i]  = end_reg <= {1'b0, gap_q[i].start};
            lt_flag[i] = end_reg < {1'b0, gap_q[i].stop};
            c_hit[i]   = (GC_W'(i) < count_reg)
                         && (e_flag[i] || (start_reg <= {1'b0, gap_q[i].stop}));
        end
        le_next[MAX_GAPS-1] = 1'b0;
        for (int i = 0; i < MAX_GAPS - 1; i++)
        begin
            le_next[i] = end_reg <= {1'b0, gap_q[i+1].start};
        end
        for (int i = 0; i < MAX_GAPS; i++)
        begin
            d_hit[i] = (GC_W'(i) < count_reg) && (GC_W'(i) >= GC_W'(g_reg))
                       && (lt_flag[i] || (GC_W'(i) == count_last) || le_next[i]);
        end
    end

    // First gap the frame reaches, and first gap where it stops.
    always_comb
    begin
        g_found = 1'b0;
        g_idx   = '0;
        j_idx   = '0;
        for (int i = MAX_GAPS - 1; i >= 0; i--)
        begin
            if (c_hit[i])
            begin
                g_found = 1'b1;
                g_idx   = GI_W'(i);
            end
            if (d_hit[i])
            begin
                j_idx = GI_W'(i);
            end
        end
    end

    // Frame table lookup: matches are unique, so an OR picks the entry.
    always_comb
    begin
        hit        = |frm_match;
        hit_len    = '0;
        hit_fin    = 1'b0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            if (frm_match[i])
            begin
                hit_len = hit_len | frm_q[i].length;
                hit_fin = hit_fin | frm_q[i].fin;
            end
        end
        for (int i = MAX_FRAMES - 1; i >= 0; i--)
        begin
            if (!frm_valid[i])
            begin
                free_found = 1'b1;
                free_idx   = FI_W'(i);
            end
        end
    end

    // Sequencer: next state, working registers and cell commands.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        rpos_next     = rpos_reg;
        limit_next    = limit_reg;
        m_valid_next  = m_valid_reg;
        op_next       = op_reg;
        off_next      = off_reg;
        len_next      = len_reg;
        fin_next      = fin_reg;
        start_next    = start_reg;
        end_next      = end_reg;
        g_next        = g_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        gs_g_next     = gs_g_reg;
        ge_g_next     = ge_g_reg;
        ge_j_next     = ge_j_reg;
        keep_j_next   = keep_j_reg;
        split_next    = split_reg;
        mod_gs_g_next = mod_gs_g_reg;
        mod_ge_g_next = mod_ge_g_reg;
        mod_gs_j_next = mod_gs_j_reg;
        ndel_next     = ndel_reg;
        pdel_next     = pdel_reg;
        status_next   = status_reg;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        m_last_next   = m_last_reg;
        s_tready      = 1'b0;
        frm_key       = off_reg;
        frm_wdata     = '{offset: start_reg[OFS_W-1:0], length: span[LEN_W-1:0],
                          fin: fin_reg};
        gap_load      = '{start: end_reg[OFS_W-1:0], stop: start_reg[OFS_W-1:0]};
        for (int i = 0; i < MAX_GAPS; i++)
        begin
            gap_cmd[i] = srgt_pkg::GAP_HOLD;
        end
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            frm_ctl[i] = '{wr: 1'b0, clr: 1'b0};
        end

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (cfg_wr_en)
        begin
            limit_next = cfg_wr_data;
        end

        unique case (state_reg)
            srgt_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op_next  = s_tuser;
                    off_next = s_tdata[OFS_W-1:0];
                    len_next = s_tdata[OFS_W+LEN_W-1:OFS_W];
                    fin_next = s_tlast;
                    state_next = (s_tuser == srgt_pkg::OP_POP) ? srgt_pkg::S_POP
                                                               : srgt_pkg::S_SAME;
                end
            end

            // Deliver the frame queued at the read position.
            srgt_pkg::S_POP:
            begin
                frm_key = rpos_reg;
                if (hit)
                begin
                    for (int i = 0; i < MAX_FRAMES; i++)
                    begin
                        frm_ctl[i].clr = frm_match[i];
                    end
                    start_next  = {1'b0, rpos_reg};
                    end_next    = {1'b0, rpos_reg} + POS_W'(hit_len);
                    fin_next    = hit_fin;
                    rpos_next   = rpos_reg + OFS_W'(hit_len);
                    status_next = srgt_pkg::STAT_OK;
                end
                else
                begin
                    status_next = srgt_pkg::STAT_IGNORED;
                end
                state_next = srgt_pkg::S_DONE;
            end

            // Empty frames and a frame already queued at the same offset.
            srgt_pkg::S_SAME:
            begin
                frm_key  = off_reg;
                end_next = {1'b0, off_reg} + POS_W'(len_reg);
                if (len_reg == '0)
                begin
                    start_next = {1'b0, off_reg};
                    end_next   = {1'b0, off_reg};
                    if (fin_reg)
                    begin
                        state_next = srgt_pkg::S_STORE;
                    end
                    else
                    begin
                        status_next = srgt_pkg::STAT_IGNORED;
                        state_next  = srgt_pkg::S_DONE;
                    end
                end
                else if (hit && (len_reg <= hit_len))
                begin
                    status_next = srgt_pkg::STAT_IGNORED;
                    state_next  = srgt_pkg::S_DONE;
                end
                else
                begin
                    start_next = {1'b0, off_reg} + POS_W'(hit ? hit_len : '0);
                    state_next = srgt_pkg::S_GFIND;
                end
            end

            // First gap at or after the frame.
            srgt_pkg::S_GFIND:
            begin
                if (!g_found || e_flag[g_idx])
                begin
                    status_next = srgt_pkg::STAT_IGNORED;
                    state_next  = srgt_pkg::S_DONE;
                end
                else
                begin
                    g_next     = g_idx;
                    gs_g_next  = gap_q[g_idx].start;
                    ge_g_next  = gap_q[g_idx].stop;
                    state_next = srgt_pkg::S_JFIND;
                end
            end

            // Gap where the frame ends; trim both ends to the gaps.
            srgt_pkg::S_JFIND:
            begin
                if (start_reg < {1'b0, gs_g_reg})
                begin
                    start_next = {1'b0, gs_g_reg};
                end
                if (!lt_flag[j_idx] && (GC_W'(j_idx) == count_last))
                begin
                    status_next = srgt_pkg::STAT_IGNORED;
                    state_next  = srgt_pkg::S_DONE;
                end
                else
                begin
                    j_next      = j_idx;
                    ge_j_next   = gap_q[j_idx].stop;
                    keep_j_next = (j_idx != g_reg) && lt_flag[j_idx];
                    if (!lt_flag[j_idx])
                    begin
                        end_next = {1'b0, gap_q[j_idx].stop};
                    end
                    state_next = srgt_pkg::S_PLAN;
                end
            end

            // Work out the gap edits and how many entries go.
            srgt_pkg::S_PLAN:
            begin
                split_next    = (start_reg != {1'b0, gs_g_reg})
                                && (end_reg != {1'b0, ge_j_reg}) && (j_reg == g_reg);
                mod_gs_g_next = 1'b0;
                mod_ge_g_next = 1'b0;
                mod_gs_j_next = 1'b0;
                if (start_reg == {1'b0, gs_g_reg})
                begin
                    if (end_reg < {1'b0, ge_j_reg})
                    begin
                        mod_gs_g_next = (j_reg == g_reg);
                        mod_gs_j_next = (j_reg != g_reg);
                    end
                end
                else if (end_reg == {1'b0, ge_j_reg})
                begin
                    mod_ge_g_next = 1'b1;
                end
                else
                begin
                    mod_ge_g_next = 1'b1;
                    mod_gs_j_next = (j_reg != g_reg);
                end
                // The first gap stays unless the frame fills it from its start.
                if ((start_reg == {1'b0, gs_g_reg}) && (end_reg >= {1'b0, ge_g_reg}))
                begin
                    ndel_next = GC_W'(j_reg) - GC_W'(g_reg) + GC_W'(1)
                                - GC_W'(keep_j_reg);
                    pdel_next = GC_W'(g_reg);
                end
                else
                begin
                    ndel_next = GC_W'(j_reg) - GC_W'(g_reg) - GC_W'(keep_j_reg);
                    pdel_next = GC_W'(g_reg) + GC_W'(1);
                end
                k_next = g_reg;
                if (split_next && (count_reg >= GC_W'(MAX_GAPS)))
                begin
                    status_next = srgt_pkg::STAT_TOO_MANY;
                    state_next  = srgt_pkg::S_DONE;
                end
                else
                begin
                    state_next = srgt_pkg::S_DROP;
                end
            end

            // Drop queued frames that start at the end of a covered gap.
            srgt_pkg::S_DROP:
            begin
                frm_key = gap_q[k_reg].stop;
                if (k_reg < j_reg)
                begin
                    for (int i = 0; i < MAX_FRAMES; i++)
                    begin
                        frm_ctl[i].clr = frm_match[i];
                    end
                    k_next = k_reg + GI_W'(1);
                end
                else
                begin
                    state_next = srgt_pkg::S_MOD;
                end
            end

            // Edit the bounds of the first and last gap touched.
            srgt_pkg::S_MOD:
            begin
                for (int i = 0; i < MAX_GAPS; i++)
                begin
                    if ((GI_W'(i) == g_reg) && mod_ge_g_reg)
                    begin
                        gap_cmd[i] = srgt_pkg::GAP_LOAD_END;
                    end
                    else if ((GI_W'(i) == g_reg) && mod_gs_g_reg)
                    begin
                        gap_cmd[i] = srgt_pkg::GAP_LOAD_START;
                    end
                    else if ((GI_W'(i) == j_reg) && mod_gs_j_reg)
                    begin
                        gap_cmd[i] = srgt_pkg::GAP_LOAD_START;
                    end
                end
                state_next = srgt_pkg::S_SHIFT;
            end

            // Insert the split-off gap, or remove one entry per cycle.
            srgt_pkg::S_SHIFT:
            begin
                if (split_reg)
                begin
                    gap_load = '{start: end_reg[OFS_W-1:0], stop: ge_g_reg};
                    for (int i = 0; i < MAX_GAPS; i++)
                    begin
                        if (GC_W'(i) == GC_W'(g_reg) + GC_W'(1))
                        begin
                            gap_cmd[i] = srgt_pkg::GAP_LOAD_BOTH;
                        end
                        else if (GC_W'(i) > GC_W'(g_reg) + GC_W'(1))
                        begin
                            gap_cmd[i] = srgt_pkg::GAP_TAKE_LEFT;
                        end
                    end
                    count_next = count_reg + GC_W'(1);
                    split_next = 1'b0;
                    state_next = srgt_pkg::S_CHECK;
                end
                else if (ndel_reg != '0)
                begin
                    for (int i = 0; i < MAX_GAPS; i++)
                    begin
                        if (GC_W'(i) >= pdel_reg)
                        begin
                            gap_cmd[i] = srgt_pkg::GAP_TAKE_RIGHT;
                        end
                    end
                    count_next = count_reg - GC_W'(1);
                    ndel_next  = ndel_reg - GC_W'(1);
                end
                else
                begin
                    state_next = srgt_pkg::S_CHECK;
                end
            end

            srgt_pkg::S_CHECK:
            begin
                if (CMP_W'(count_reg) > CMP_W'(limit_reg))
                begin
                    status_next = srgt_pkg::STAT_TOO_MANY;
                    state_next  = srgt_pkg::S_DONE;
                end
                else
                begin
                    state_next = srgt_pkg::S_STORE;
                end
            end

            // Queue the frame: same offset first, else the first free slot.
            srgt_pkg::S_STORE:
            begin
                frm_key     = start_reg[OFS_W-1:0];
                status_next = srgt_pkg::STAT_OK;
                if (hit)
                begin
                    for (int i = 0; i < MAX_FRAMES; i++)
                    begin
                        frm_ctl[i].wr = frm_match[i];
                    end
                end
                else if (free_found)
                begin
                    for (int i = 0; i < MAX_FRAMES; i++)
                    begin
                        frm_ctl[i].wr = (FI_W'(i) == free_idx);
                    end
                end
                else
                begin
                    status_next = srgt_pkg::STAT_FULL;
                end
                state_next = srgt_pkg::S_DONE;
            end

            // Hand the result to the output register once it is free.
            srgt_pkg::S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = status_reg;
                    if (status_reg == srgt_pkg::STAT_IGNORED)
                    begin
                        m_data_next = {{srgt_pkg::OUT_PAD_W{1'b0}}, rpos_reg,
                                       {LEN_W{1'b0}}, {OFS_W{1'b0}}};
                        m_last_next = 1'b0;
                    end
                    else
                    begin
                        m_data_next = {{srgt_pkg::OUT_PAD_W{1'b0}}, rpos_reg,
                                       span[LEN_W-1:0], start_reg[OFS_W-1:0]};
                        m_last_next = fin_reg;
                    end
                    state_next = srgt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = srgt_pkg::S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= srgt_pkg::S_IDLE;
            count_reg   <= GC_W'(1);
            rpos_reg    <= '0;
            limit_reg   <= srgt_pkg::LIMIT_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rpos_reg    <= rpos_next;
            limit_reg   <= limit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working and output payload.
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        off_reg      <= off_next;
        len_reg      <= len_next;
        fin_reg      <= fin_next;
        start_reg    <= start_next;
        end_reg      <= end_next;
        g_reg        <= g_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        gs_g_reg     <= gs_g_next;
        ge_g_reg     <= ge_g_next;
        ge_j_reg     <= ge_j_next;
        keep_j_reg   <= keep_j_next;
        split_reg    <= split_next;
        mod_gs_g_reg <= mod_gs_g_next;
        mod_ge_g_reg <= mod_ge_g_next;
        mod_gs_j_reg <= mod_gs_j_next;
        ndel_reg     <= ndel_next;
        pdel_reg     <= pdel_next;
        status_reg   <= status_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // Checks on the gap list, the frame table and the result handoff.
    `SRGT_ASSERT_ALWAYS(a_gap_count_range, clk, rst_n,
        (count_reg != '0) && (count_reg <= GC_W'(MAX_GAPS)),
        "gap count out of range")
    `SRGT_ASSERT_ALWAYS(a_frame_offset_unique, clk, rst_n,
        $onehot0(frm_match),
        "two queued frames share one offset")
    `SRGT_ASSERT_NEXT(a_result_loaded, clk, rst_n,
        (state_reg == srgt_pkg::S_DONE) && (!m_valid_reg || m_tready),
        m_valid_reg && (state_reg == srgt_pkg::S_IDLE),
        "finished result not presented")
    `SRGT_ASSERT_NEXT(a_push_op_kept, clk, rst_n,
        (state_reg == srgt_pkg::S_SAME),
        (op_reg == srgt_pkg::OP_PUSH),
        "push sequence entered for a pop")

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ---------------------------------------------------------------------------
// Testbench for stream_reassembly_gap_tracker_unit
// Drives push and pop requests on the input stream with random gaps and
// checks every result against an in-bench gap list and frame table predictor
// or a directed row's typed result. A short directed table comes first.
// Random phases follow, one per gap limit setting, and one phase holds the
// result stream off for a long stretch so that the block backs up.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
    import srgt_pkg::*;

    localparam int NGAPS       = 64;
    localparam int NFRAMES     = 64;
    localparam int IDLE_LIMIT  = 20000;
    localparam int SETTLE      = 300;
    localparam int HOLD_CYCLES = 400;
    localparam logic [63:0] OFS_MASK = 64'h3FFF_FFFF_FFFF_FFFF;

    // One expected result.
    typedef struct {
        status_t          status;
        logic [OFS_W-1:0] offset;
        logic [LEN_W-1:0] length;
        logic             fin;
        logic [OFS_W-1:0] rd;
    } result_t;

    // One row of the directed stimulus; typed marks a hand-written result.
    typedef struct {
        logic             op;
        logic [OFS_W-1:0] offset;
        logic [LEN_W-1:0] length;
        logic             fin;
        bit               typed;
        result_t          res;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]             m_tuser;
    logic                   m_tlast;
    logic                   cfg_wr_en;
    logic [LIM_W-1:0]       cfg_wr_data;

    // Predicted block state.
    logic [63:0] gap_lo [NGAPS];
    logic [63:0] gap_hi [NGAPS];
    int          gap_num;
    logic [63:0] frm_ofs [NFRAMES];
    logic [63:0] frm_len [NFRAMES];
    logic        frm_fin [NFRAMES];
    bit          frm_vld [NFRAMES];
    logic [63:0] read_pos;
    logic [63:0] gap_limit;

    result_t     pending_results[$];
    stim_row_t   directed_rows[$];
    int          errors;
    int          idle_cycles;
    int          hold_id;
    int          hold_seen;
    int          hold_left;
    int          rx_wait;

    stream_reassembly_gap_tracker_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Clock with a period of 12.
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Frame table lookup by offset, -1 when absent.
    function automatic int frame_at(logic [63:0] ofs);
        for (int i = 0; i < NFRAMES; i++)
            if (frm_vld[i] && frm_ofs[i] == ofs)
                return i;
        return -1;
    endfunction

    // Queue a frame, overwriting one at the same offset; full gives STAT_FULL.
    function automatic status_t queue_frame(logic [63:0] ofs, logic [63:0] len,
                                            logic fin);
        int k;
        k = frame_at(ofs);
        if (k < 0)
            for (int i = 0; i < NFRAMES && k < 0; i++)
                if (!frm_vld[i])
                    k = i;
        if (k < 0)
            return STAT_FULL;
        frm_ofs[k] = ofs;
        frm_len[k] = len;
        frm_fin[k] = fin;
        frm_vld[k] = 1'b1;
        return STAT_OK;
    endfunction

    // Push: trim the frame to the gaps it fills and update the gap list.
    function automatic status_t fill_gaps(logic [63:0] ofs, logic [63:0] len,
                                          logic fin, output logic [63:0] o_ofs,
                                          output logic [63:0] o_len);
        logic [63:0] ns [NGAPS];
        logic [63:0] ne [NGAPS];
        logic [63:0] lo, hi, old_hi;
        int          g, j, n, same;
        bit          removed_j, keep_g, keep_j, split;
        removed_j = 0;
        keep_g = 1;
        split = 0;
        o_ofs = 0;
        o_len = 0;
        if (len == 0)
        begin
            if (!fin)
                return STAT_IGNORED;
            o_ofs = ofs;
            return queue_frame(ofs, 0, 1'b1);
        end
        same = frame_at(ofs);
        if (same >= 0)
        begin
            if (len <= frm_len[same])
                return STAT_IGNORED;
            ofs += frm_len[same];
            len -= frm_len[same];
        end
        lo = ofs;
        hi = ofs + len;
        for (g = 0; g < gap_num; g++)
        begin
            if (hi <= gap_lo[g])
                return STAT_IGNORED;
            if (lo <= gap_hi[g])
                break;
        end
        if (g >= gap_num)
            return STAT_IGNORED;
        if (lo < gap_lo[g])
        begin
            len -= gap_lo[g] - lo;
            lo = gap_lo[g];
        end
        // Walk forward over the gaps the frame runs through.
        j = g;
        while (hi >= gap_hi[j])
        begin
            if (j + 1 >= gap_num)
                return STAT_IGNORED;
            if (hi <= gap_lo[j+1])
            begin
                removed_j = (j != g);
                break;
            end
            j++;
        end
        if (hi > gap_hi[j])
        begin
            len -= hi - gap_hi[j];
            hi = gap_hi[j];
        end
        o_ofs = lo;
        o_len = len;
        if (lo != gap_lo[g] && hi != gap_hi[j] && j == g)
        begin
            split = 1;
            if (gap_num >= NGAPS)
                return STAT_TOO_MANY;
        end
        // Frames at the end of a gap that is filled are covered now.
        for (int k = g; k < j; k++)
        begin
            same = frame_at(gap_hi[k]);
            if (same >= 0)
                frm_vld[same] = 1'b0;
        end
        old_hi = gap_hi[g];
        keep_j = (j != g) && !removed_j;
        if (lo == gap_lo[g])
        begin
            if (hi >= gap_hi[g])
                keep_g = 0;
            if (hi < gap_hi[j])
                gap_lo[j] = hi;
        end
        else if (hi == gap_hi[j])
            gap_hi[g] = lo;
        else
        begin
            gap_hi[g] = lo;
            if (j != g)
                gap_lo[j] = hi;
        end
        // Rebuild the sorted list.
        n = 0;
        for (int i = 0; i < g; i++)
        begin
            ns[n] = gap_lo[i]; ne[n] = gap_hi[i]; n++;
        end
        if (keep_g)
        begin
            ns[n] = gap_lo[g]; ne[n] = gap_hi[g]; n++;
        end
        if (split)
        begin
            ns[n] = hi; ne[n] = old_hi; n++;
        end
        if (keep_j)
        begin
            ns[n] = gap_lo[j]; ne[n] = gap_hi[j]; n++;
        end
        for (int i = j + 1; i < gap_num; i++)
        begin
            ns[n] = gap_lo[i]; ne[n] = gap_hi[i]; n++;
        end
        for (int i = 0; i < n; i++)
        begin
            gap_lo[i] = ns[i];
            gap_hi[i] = ne[i];
        end
        gap_num = n;
        if (gap_num > gap_limit)
            return STAT_TOO_MANY;
        return queue_frame(lo, len, fin);
    endfunction

    // Predict the result of one request and advance the predicted state.
    function automatic result_t predict_request(logic op, logic [63:0] ofs,
                                                logic [63:0] len, logic fin);
        result_t     r;
        logic [63:0] o_ofs, o_len;
        int          k;
        r.offset = '0;
        r.length = '0;
        r.fin    = 1'b0;
        if (op == OP_PUSH)
        begin
            r.status = fill_gaps(ofs, len, fin, o_ofs, o_len);
            if (r.status != STAT_IGNORED)
            begin
                r.offset = o_ofs[OFS_W-1:0];
                r.length = o_len[LEN_W-1:0];
                r.fin    = fin;
            end
        end
        else
        begin
            k = frame_at(read_pos);
            if (k >= 0)
            begin
                r.offset = frm_ofs[k][OFS_W-1:0];
                r.length = frm_len[k][LEN_W-1:0];
                r.fin    = frm_fin[k];
                frm_vld[k] = 1'b0;
                read_pos = (read_pos + frm_len[k]) & OFS_MASK;
                r.status = STAT_OK;
            end
            else
                r.status = STAT_IGNORED;
        end
        r.rd = read_pos[OFS_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
        errors++;
    endtask

    // Send one request after a random gap; predict it once it is accepted.
    task automatic send_request(input logic op, input logic [63:0] ofs,
                                input logic [63:0] len, input logic fin,
                                input bit typed, input result_t typed_res);
        int      gap;
        result_t r;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= fin;
        s_tdata  <= {2'b00, len[LEN_W-1:0], ofs[OFS_W-1:0]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = predict_request(op, ofs & OFS_MASK, len & 64'hFFFF, fin);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic send_pred(input logic op, input logic [63:0] ofs,
                             input logic [63:0] len, input logic fin);
        result_t none;
        send_request(op, ofs, len, fin, 1'b0, none);
    endtask

    function automatic void add_row(logic op, logic [63:0] ofs, logic [63:0] len,
                                    logic fin, bit typed, status_t st,
                                    logic [63:0] e_ofs, logic [63:0] e_len,
                                    logic e_fin, logic [63:0] e_rd);
        stim_row_t row;
        row.op = op;
        row.offset = ofs[OFS_W-1:0];
        row.length = len[LEN_W-1:0];
        row.fin = fin;
        row.typed = typed;
        row.res.status = st;
        row.res.offset = e_ofs[OFS_W-1:0];
        row.res.length = e_len[LEN_W-1:0];
        row.res.fin = e_fin;
        row.res.rd = e_rd[OFS_W-1:0];
        directed_rows.push_back(row);
    endfunction

    // Wait until the block is idle, then write the gap limit.
    task automatic write_gap_limit(input logic [LIM_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        gap_limit = value;
    endtask

    // In-order run of frames from the read position, pushed shuffled.
    task automatic send_run();
        logic [63:0] p_ofs [12];
        logic [63:0] p_len [12];
        logic [63:0] t, pos;
        int          n, a, b;
        n = $urandom_range(1, 12);
        pos = read_pos;
        for (int i = 0; i < n; i++)
        begin
            p_ofs[i] = pos;
            p_len[i] = ($urandom_range(0, 30) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(1, 300);
            pos += p_len[i];
        end
        for (int i = 0; i < n; i++)
        begin
            a = $urandom_range(0, n - 1);
            b = $urandom_range(0, n - 1);
            t = p_ofs[a]; p_ofs[a] = p_ofs[b]; p_ofs[b] = t;
            t = p_len[a]; p_len[a] = p_len[b]; p_len[b] = t;
        end
        for (int i = 0; i < n; i++)
        begin
            t = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 80) : 0;
            send_pred(OP_PUSH, p_ofs[i], p_len[i] + t, $urandom_range(0, 5) == 0);
        end
        for (int i = 0; i <= n; i++)
            send_pred(OP_POP, {$urandom, $urandom}, $urandom_range(0, 65535),
                      $urandom_range(0, 1));
    endtask

    // Noise: stray, far, duplicate, empty and wild requests.
    task automatic send_noise();
        logic [63:0] ofs;
        case ($urandom_range(0, 5))
            0: ofs = read_pos + $urandom_range(0, 20000);
            1: ofs = {$urandom, $urandom};
            2: ofs = OFS_MASK - $urandom_range(0, 70000);
            3: ofs = read_pos - $urandom_range(0, 500);
            default: ofs = read_pos + $urandom_range(300, 5000);
        endcase
        if ($urandom_range(0, 6) == 0)
            send_pred(OP_POP, ofs, 0, 1'b0);
        else
            send_pred(OP_PUSH, ofs,
                      ($urandom_range(0, 8) == 0) ? 0 :
                      ($urandom_range(0, 8) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(1, 200),
                      $urandom_range(0, 3) == 0);
    endtask

    // Result receiver: random stalls, one long hold-off, and checking.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        logic    nxt;
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            rx_wait   = 0;
            hold_left = 0;
            hold_seen = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected result, status", m_tuser, 0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tuser != want.status)
                        report_mismatch("status", m_tuser, want.status);
                    if (m_tdata[OFS_W-1:0] != want.offset)
                        report_mismatch("out_offset", m_tdata[OFS_W-1:0], want.offset);
                    if (m_tdata[OFS_W+LEN_W-1:OFS_W] != want.length)
                        report_mismatch("out_length", m_tdata[OFS_W+LEN_W-1:OFS_W],
                                        want.length);
                    if (m_tlast != want.fin)
                        report_mismatch("out_fin", m_tlast, want.fin);
                    if (m_tdata[2*OFS_W+LEN_W-1:OFS_W+LEN_W] != want.rd)
                        report_mismatch("read_offset",
                                        m_tdata[2*OFS_W+LEN_W-1:OFS_W+LEN_W], want.rd);
                end
                rx_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            end
            if (hold_id != hold_seen)
            begin
                hold_seen = hold_id;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                nxt = 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                nxt = 1'b0;
            end
            else
                nxt = 1'b1;
            m_tready <= nxt;
        end
    end

    // Watchdog on cycles without any accepted request or result.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Main stimulus.
    initial
    begin
        logic [LIM_W-1:0] limits [6];
        int               sent;
        errors      = 0;
        idle_cycles = 0;
        hold_id     = 0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_PUSH;
        s_tlast     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;

        // Predicted reset state.
        for (int i = 0; i < NGAPS; i++)
        begin
            gap_lo[i] = 0;
            gap_hi[i] = 0;
        end
        gap_hi[0] = OFS_MASK;
        gap_num   = 1;
        for (int i = 0; i < NFRAMES; i++)
            frm_vld[i] = 1'b0;
        read_pos  = 0;
        gap_limit = LIMIT_RESET;

        // Directed rows; typed results where they are obvious.
        add_row(OP_POP,  0, 0, 0, 1, STAT_IGNORED, 0, 0, 0, 0);
        add_row(OP_PUSH, 7, 0, 0, 1, STAT_IGNORED, 0, 0, 0, 0);
        add_row(OP_PUSH, 0, 100, 0, 1, STAT_OK, 0, 100, 0, 0);
        add_row(OP_POP,  0, 0, 0, 1, STAT_OK, 0, 100, 0, 100);
        add_row(OP_PUSH, 0, 50, 0, 1, STAT_IGNORED, 0, 0, 0, 100);
        add_row(OP_PUSH, 5000, 0, 1, 1, STAT_OK, 5000, 0, 1, 100);
        add_row(OP_PUSH, OFS_MASK, 1, 1, 1, STAT_IGNORED, 0, 0, 0, 100);
        add_row(OP_PUSH, OFS_MASK - 10, 65535, 0, 1, STAT_IGNORED, 0, 0, 0, 100);
        add_row(OP_PUSH, 200, 65535, 1, 1, STAT_OK, 200, 65535, 1, 100);
        add_row(OP_PUSH, 200, 65535, 0, 1, STAT_IGNORED, 0, 0, 0, 100);
        add_row(OP_PUSH, 200, 65600, 0, 0, STAT_OK, 0, 0, 0, 0);
        add_row(OP_PUSH, 150, 100, 0, 0, STAT_OK, 0, 0, 0, 0);
        add_row(OP_PUSH, 90, 20, 0, 0, STAT_OK, 0, 0, 0, 0);
        add_row(OP_PUSH, 120, 10, 0, 0, STAT_OK, 0, 0, 0, 0);
        add_row(OP_PUSH, 100, 70000 - 65535, 0, 0, STAT_OK, 0, 0, 0, 0);
        add_row(OP_POP,  0, 0, 0, 0, STAT_OK, 0, 0, 0, 0);
        add_row(OP_POP,  0, 0, 0, 0, STAT_OK, 0, 0, 0, 0);
        add_row(OP_POP,  0, 0, 0, 0, STAT_OK, 0, 0, 0, 0);
        add_row(OP_POP,  0, 0, 0, 0, STAT_OK, 0, 0, 0, 0);
        add_row(OP_PUSH, 64'h2AAA_AAAA_AAAA_AAAA, 64'h5555, 1, 0, STAT_OK, 0, 0, 0, 0);
        add_row(OP_PUSH, 64'h1555_5555_5555_5555, 64'hAAAA, 0, 0, STAT_OK, 0, 0, 0, 0);
        add_row(OP_POP,  OFS_MASK, 65535, 1, 0, STAT_OK, 0, 0, 0, 0);

        repeat (12) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].offset,
                         directed_rows[i].length, directed_rows[i].fin,
                         directed_rows[i].typed, directed_rows[i].res);

        // Random phases, one per gap limit, the extremes among them.
        limits = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd20, 7'd64};
        foreach (limits[p])
        begin
            write_gap_limit(limits[p]);
            if (p == 3)
                hold_id++;
            sent = 0;
            while (sent < 230)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    // A run sends 14 requests on average.
                    send_run();
                    sent += 14;
                end
                else
                begin
                    send_noise();
                    sent++;
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
